// ===== rtl/ils_pkg.sv =====
// Package of shared types and codes for the indexed linked stack unit.
`timescale 1ns / 1ps
`default_nettype none

package ils_pkg;

  // Size of the slot pool; the beat field widths below are sized for it
  localparam int unsigned SLOTS = 256;

  // Fixed widths of the beat fields
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned FILL_W   = 9;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned ERROR_W  = 2;

  // Action codes of an input beat
  localparam logic [ACTION_W-1:0] ACT_PUSH   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_POP    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_FILL   = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 3'd5;

  // Error codes of a result beat
  typedef enum logic [ERROR_W-1:0] {
    ERR_OK          = 2'd0,
    ERR_REMOVE_MISS = 2'd1,
    ERR_PUSH_MEMBER = 2'd2
  } err_e;

  // Datapath step commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_PUSH,
    CMD_PUSH_LINK,
    CMD_POP_READ,
    CMD_RM_READ,
    CMD_UNLINK,
    CMD_CLEAR,
    CMD_FILL_START,
    CMD_FILL_STEP
  } dp_cmd_e;

  // Controller to datapath
  typedef struct packed {
    dp_cmd_e op;
    logic    emit;
    err_e    err;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;
    logic slot_member;
    logic head_valid;
    logic fill_zero;
    logic fill_last;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/ils_req_if.sv =====
// Request channel interface: one stack operation per beat.
`timescale 1ns / 1ps
`default_nettype none

interface ils_req_if
  import ils_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [SLOT_W-1:0]   slot;
  logic [FILL_W-1:0]   fill_count;

  modport source (output valid, action, slot, fill_count, input ready);
  modport sink   (input valid, action, slot, fill_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/ils_rsp_if.sv =====
// Response channel interface: one result per beat.
`timescale 1ns / 1ps
`default_nettype none

interface ils_rsp_if
  import ils_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [SLOT_W-1:0]  slot_out;
  logic               slot_valid;
  logic [COUNT_W-1:0] item_count;
  logic               is_empty;
  logic [ERROR_W-1:0] error;

  modport source (output valid, slot_out, slot_valid, item_count, is_empty, error,
                  input ready);
  modport sink   (input valid, slot_out, slot_valid, item_count, is_empty, error,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/ils_ctrl.sv =====
// Controller state machine sequencing each stack operation.
`timescale 1ns / 1ps
`default_nettype none

module ils_ctrl
  import ils_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic [ACTION_W-1:0] in_action_i,
  input  wire logic                out_ready_i,
  input  wire sts_t                sts_i,
  output logic                     in_ready_o,
  output cmd_t                     cmd_o
);

  localparam logic [1:0] ST_IDLE      = 2'd0;
  localparam logic [1:0] ST_PUSH_LINK = 2'd1;
  localparam logic [1:0] ST_UNLINK    = 2'd2;
  localparam logic [1:0] ST_FILL      = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  // Take a beat only when idle and the result register is free or draining
  assign in_ready_o = (state_q == ST_IDLE) && (!sts_i.out_busy || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // Decode the operation and pick the datapath step
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = CMD_NONE;
    cmd_o.emit = 1'b0;
    cmd_o.err  = ERR_OK;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_action_i)
            ACT_PUSH: begin
              if (sts_i.slot_free) begin
                cmd_o.op = CMD_PUSH;
                if (sts_i.head_valid) begin
                  state_d = ST_PUSH_LINK;
                end else begin
                  cmd_o.emit = 1'b1;
                end
              end else begin
                cmd_o.emit = 1'b1;
                cmd_o.err  = ERR_PUSH_MEMBER;
              end
            end
            ACT_POP: begin
              if (sts_i.head_valid) begin
                cmd_o.op = CMD_POP_READ;
                state_d  = ST_UNLINK;
              end else begin
                cmd_o.emit = 1'b1;
              end
            end
            ACT_REMOVE: begin
              if (sts_i.slot_member) begin
                cmd_o.op = CMD_RM_READ;
                state_d  = ST_UNLINK;
              end else begin
                cmd_o.emit = 1'b1;
                cmd_o.err  = ERR_REMOVE_MISS;
              end
            end
            ACT_CLEAR: begin
              cmd_o.op   = CMD_CLEAR;
              cmd_o.emit = 1'b1;
            end
            ACT_FILL: begin
              cmd_o.op = CMD_FILL_START;
              if (sts_i.fill_zero) begin
                cmd_o.emit = 1'b1;
              end else begin
                state_d = ST_FILL;
              end
            end
            default: begin
              // query and unused codes only report
              cmd_o.emit = 1'b1;
            end
          endcase
        end
      end
      ST_PUSH_LINK: begin
        cmd_o.op   = CMD_PUSH_LINK;
        cmd_o.emit = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_UNLINK: begin
        cmd_o.op   = CMD_UNLINK;
        cmd_o.emit = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_FILL: begin
        cmd_o.op = CMD_FILL_STEP;
        if (sts_i.fill_last) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ils_dpath.sv =====
// Datapath: link memories, membership flags, head, tail, count and result register.
`timescale 1ns / 1ps
`default_nettype none

module ils_dpath
  import ils_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  input  wire logic [SLOT_W-1:0]   in_slot_i,
  input  wire logic [FILL_W-1:0]   in_fill_count_i,
  input  wire logic                out_ready_i,
  output sts_t                     sts_o,
  output logic                     out_valid_o,
  output logic [SLOT_W-1:0]        out_slot_o,
  output logic                     out_slot_valid_o,
  output logic [COUNT_W-1:0]       out_item_count_o,
  output logic                     out_is_empty_o,
  output logic [ERROR_W-1:0]       out_error_o
);

  localparam int unsigned SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW   = $clog2(SLOTS + 1);
  localparam int unsigned CMPW = (CW > FILL_W) ? CW : FILL_W;
  localparam logic [CW-1:0]   NIL     = CW'(SLOTS);
  localparam logic [CMPW-1:0] SLOTS_C = CMPW'(SLOTS);

  // Link memories, one write and one registered read port each
  logic [CW-1:0] next_mem [SLOTS];
  logic [CW-1:0] prev_mem [SLOTS];

  logic [SLOTS-1:0] member_q;
  logic [CW-1:0]    head_q, head_d;
  logic [CW-1:0]    tail_q, tail_d;
  logic [CW-1:0]    count_q, count_d;
  logic [SW-1:0]    target_q;
  logic [CW-1:0]    aux_q;
  logic             pop_q;
  logic [SW-1:0]    fill_idx_q;
  logic [CW-1:0]    lim_q;
  logic [CW-1:0]    next_rd_q, prev_rd_q;

  logic              out_valid_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic              out_slot_valid_q;
  logic [COUNT_W-1:0] out_count_q;
  logic              out_empty_q;
  logic [ERROR_W-1:0] out_err_q;

  logic [CMPW-1:0] slot_ext, fill_ext;
  logic [SW-1:0]   slot_idx;
  logic            slot_in_range, slot_is_member;
  logic [CW-1:0]   lim;
  logic [CW-1:0]   fill_idx_w, fill_idx_inc;
  logic [CW-1:0]   link_p, link_n, target_w, shown;

  logic            nx_we, pv_we, rd_en;
  logic [SW-1:0]   nx_wa, pv_wa, rd_addr;
  logic [CW-1:0]   nx_wd, pv_wd;
  logic            flag_clr_all, flag_set, flag_clr;
  logic [SW-1:0]   flag_idx;

  // Decode the beat's slot and fill length
  assign slot_ext       = CMPW'(in_slot_i);
  assign fill_ext       = CMPW'(in_fill_count_i);
  assign slot_idx       = slot_ext[SW-1:0];
  assign slot_in_range  = slot_ext < SLOTS_C;
  assign slot_is_member = member_q[slot_idx];
  assign lim            = (fill_ext > SLOTS_C) ? NIL : CW'(fill_ext);

  assign fill_idx_w   = CW'(fill_idx_q);
  assign fill_idx_inc = fill_idx_w + CW'(1);
  assign target_w     = CW'(target_q);
  assign link_p       = prev_rd_q;
  assign link_n       = next_rd_q;

  // Status to the controller
  assign sts_o.slot_free   = slot_in_range && !slot_is_member;
  assign sts_o.slot_member = slot_in_range && slot_is_member;
  assign sts_o.head_valid  = (head_q != NIL);
  assign sts_o.fill_zero   = (fill_ext == '0);
  assign sts_o.fill_last   = (fill_idx_inc == lim_q);
  assign sts_o.out_busy    = out_valid_q;

  // Work out the step: link writes, flag updates and next list registers
  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    nx_we        = 1'b0;
    nx_wa        = '0;
    nx_wd        = NIL;
    pv_we        = 1'b0;
    pv_wa        = '0;
    pv_wd        = NIL;
    rd_en        = 1'b0;
    rd_addr      = slot_idx;
    flag_clr_all = 1'b0;
    flag_set     = 1'b0;
    flag_clr     = 1'b0;
    flag_idx     = slot_idx;
    case (cmd_i.op)
      CMD_PUSH: begin
        nx_we    = 1'b1;
        nx_wa    = slot_idx;
        nx_wd    = head_q;
        pv_we    = 1'b1;
        pv_wa    = slot_idx;
        pv_wd    = NIL;
        flag_set = 1'b1;
        head_d   = CW'(slot_idx);
        if (head_q == NIL) begin
          tail_d = CW'(slot_idx);
        end
        count_d = count_q + CW'(1);
      end
      CMD_PUSH_LINK: begin
        pv_we = 1'b1;
        pv_wa = aux_q[SW-1:0];
        pv_wd = target_w;
      end
      CMD_POP_READ: begin
        rd_en   = 1'b1;
        rd_addr = head_q[SW-1:0];
      end
      CMD_RM_READ: begin
        rd_en   = 1'b1;
        rd_addr = slot_idx;
      end
      CMD_UNLINK: begin
        if (head_q == target_w) begin
          head_d = link_n;
          if (link_n != NIL) begin
            pv_we = 1'b1;
            pv_wa = link_n[SW-1:0];
            pv_wd = NIL;
          end else begin
            tail_d = NIL;
          end
        end else if (tail_q == target_w) begin
          if (link_p != NIL) begin
            tail_d = link_p;
            nx_we  = 1'b1;
            nx_wa  = link_p[SW-1:0];
            nx_wd  = NIL;
          end
        end else if (link_p != NIL && link_n != NIL) begin
          nx_we = 1'b1;
          nx_wa = link_p[SW-1:0];
          nx_wd = link_n;
          pv_we = 1'b1;
          pv_wa = link_n[SW-1:0];
          pv_wd = link_p;
        end
        flag_clr = 1'b1;
        flag_idx = target_q;
        if (count_q != '0) begin
          count_d = count_q - CW'(1);
        end
      end
      CMD_CLEAR, CMD_FILL_START: begin
        flag_clr_all = 1'b1;
        head_d       = NIL;
        tail_d       = NIL;
        count_d      = '0;
      end
      CMD_FILL_STEP: begin
        // slot i sits above slot i-1; the last slot pushed is the top
        nx_we    = 1'b1;
        nx_wa    = fill_idx_q;
        nx_wd    = (fill_idx_q == '0) ? NIL : fill_idx_w - CW'(1);
        pv_we    = 1'b1;
        pv_wa    = fill_idx_q;
        pv_wd    = (fill_idx_inc == lim_q) ? NIL : fill_idx_inc;
        flag_set = 1'b1;
        flag_idx = fill_idx_q;
        head_d   = fill_idx_w;
        tail_d   = '0;
        count_d  = fill_idx_inc;
      end
      default: begin
      end
    endcase
  end

  // Popped slot for a pop, otherwise the top after the step
  assign shown = (cmd_i.op == CMD_UNLINK && pop_q) ? target_w : head_d;

  // Link memories
  always_ff @(posedge clk_i) begin
    if (nx_we) begin
      next_mem[nx_wa] <= nx_wd;
    end
    if (pv_we) begin
      prev_mem[pv_wa] <= pv_wd;
    end
    if (rd_en) begin
      next_rd_q <= next_mem[rd_addr];
      prev_rd_q <= prev_mem[rd_addr];
    end
  end

  // Operation scratch registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_PUSH: begin
        target_q <= slot_idx;
        aux_q    <= head_q;
      end
      CMD_POP_READ: begin
        target_q <= head_q[SW-1:0];
        pop_q    <= 1'b1;
      end
      CMD_RM_READ: begin
        target_q <= slot_idx;
        pop_q    <= 1'b0;
      end
      CMD_FILL_START: begin
        lim_q      <= lim;
        fill_idx_q <= '0;
      end
      CMD_FILL_STEP: begin
        fill_idx_q <= fill_idx_q + SW'(1);
      end
      default: begin
      end
    endcase
  end

  // List registers and membership flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= NIL;
      tail_q   <= NIL;
      count_q  <= '0;
      member_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      if (flag_clr_all) begin
        member_q <= '0;
      end else if (flag_set) begin
        member_q[flag_idx] <= 1'b1;
      end else if (flag_clr) begin
        member_q[flag_idx] <= 1'b0;
      end
    end
  end

  // Result register: load on emit, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_slot_valid_q <= (shown != NIL);
      out_slot_q       <= (shown != NIL) ? SLOT_W'(shown) : '0;
      out_count_q      <= COUNT_W'(count_d);
      out_empty_q      <= (count_d == '0);
      out_err_q        <= cmd_i.err;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_slot_o       = out_slot_q;
  assign out_slot_valid_o = out_slot_valid_q;
  assign out_item_count_o = out_count_q;
  assign out_is_empty_o   = out_empty_q;
  assign out_error_o      = out_err_q;

endmodule

`default_nettype wire

// ===== rtl/indexed_linked_stack_unit.sv =====
// Top level of the indexed linked stack unit: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// Doubly linked stack over SLOTS numbered slots. Each request beat carries one
// operation and yields exactly one response beat. Query, clear, rejected
// operations and pop or push on an empty stack end in the idle state; push
// onto a non-empty stack adds the push-link state, pop and remove the unlink
// state after a link read, as each reads or rewrites neighbour links through
// the single write port of each link memory. Fill clears, then writes one
// slot's links a cycle. A new request is taken once the previous result has
// been taken or is being taken in the same cycle. Link memories need no
// clearing pass after reset: only links of member slots are ever read.
module indexed_linked_stack_unit
  import ils_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ils_req_if.sink   req_i,
  ils_rsp_if.source rsp_o
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign req_i.ready = in_ready;

  ils_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_action_i (req_i.action),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .in_ready_o  (in_ready),
    .cmd_o       (cmd)
  );

  ils_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .in_slot_i        (req_i.slot),
    .in_fill_count_i  (req_i.fill_count),
    .out_ready_i      (rsp_o.ready),
    .sts_o            (sts),
    .out_valid_o      (rsp_o.valid),
    .out_slot_o       (rsp_o.slot_out),
    .out_slot_valid_o (rsp_o.slot_valid),
    .out_item_count_o (rsp_o.item_count),
    .out_is_empty_o   (rsp_o.is_empty),
    .out_error_o      (rsp_o.error)
  );

endmodule

`default_nettype wire
